### rtl/tip_pkg.sv
// Shared types and constants for the tiled 8-bit color image packer.
// Used by every module of the block but the frame store; depends on nothing.
package tip_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int DIV_NUM_W  = 10;
  localparam int DIV_DEN_W  = 5;
  localparam int DIV_CNT_W  = 4;
  localparam int POS_W      = 14;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_EMIT = 1'b1;
  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h47, 8'h52, 8'h42, 8'h38};
  localparam logic [7:0] END_BYTE = 8'h2E;
  localparam logic [2:0] HDR_DIMS = 3'd4;
  localparam logic [2:0] HDR_ROWS = 3'd5;
  localparam logic [2:0] HDR_LAST = 3'd6;

  typedef enum logic [1:0] {
    REG_CHUNK_W,
    REG_CHUNK_H,
    REG_IMG_W,
    REG_IMG_H
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_END
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] cw;
    logic [4:0] ch;
    logic [8:0] w;
    logic [8:0] h;
    logic [7:0] rows;
    logic [7:0] cols;
  } dims_t;

  function automatic logic [7:0] pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {g[7:5], r[7:5], b[7:6]};
  endfunction

endpackage

### rtl/tip_div.sv
// Restoring divider, one quotient bit per cycle, for chunk count computation.
// Depends on tip_pkg for operand widths.
module tip_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tip_pkg::DIV_NUM_W-1:0] num,
  input  logic [tip_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [7:0]                    quot
);
  import tip_pkg::*;

  logic [DIV_NUM_W-1:0] num_sh;
  logic [DIV_NUM_W-1:0] q;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] trial;
  logic                 q_bit;
  logic [DIV_CNT_W-1:0] cnt;

  assign trial = {rem[DIV_DEN_W-2:0], num_sh[DIV_NUM_W-1]};
  assign q_bit = (trial >= den_r);
  assign quot  = q[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      q      <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[DIV_NUM_W-2:0], 1'b0};
      rem    <= q_bit ? (trial - den_r) : trial;
      q      <= {q[DIV_NUM_W-2:0], q_bit};
    end
  end

endmodule

### rtl/tip_regs.sv
// Configuration registers on the APB port, size clamping and chunk counts.
// Depends on tip_pkg and tip_div.
module tip_regs #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_CHUNK  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tip_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tip_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tip_pkg::APB_DATA_W-1:0] prdata,
  output tip_pkg::dims_t                 dims
);
  import tip_pkg::*;

  localparam logic [8:0] W_CAP = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
  localparam logic [8:0] H_CAP = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);
  localparam logic [4:0] C_CAP = 5'(MAX_CHUNK);

  logic [4:0] chunk_width;
  logic [4:0] chunk_height;
  logic [8:0] frame_width;
  logic [8:0] frame_height;
  logic       stale;
  logic       wr;
  logic       div_go;
  logic       rows_busy;
  logic       cols_busy;
  logic [4:0] eff_cw;
  logic [4:0] eff_ch;
  logic [8:0] eff_w;
  logic [8:0] eff_h;
  logic [7:0] rows;
  logic [7:0] cols;
  reg_idx_t   idx;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign div_go = stale && !rows_busy && !cols_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_width  <= 5'd16;
      chunk_height <= 5'd16;
      frame_width  <= 9'd256;
      frame_height <= 9'd256;
      stale        <= 1'b1;
    end else begin
      if (div_go) begin
        stale <= 1'b0;
      end
      if (wr) begin
        stale <= 1'b1;
        case (idx)
          REG_CHUNK_W: chunk_width  <= pwdata[4:0];
          REG_CHUNK_H: chunk_height <= pwdata[4:0];
          REG_IMG_W:   frame_width  <= pwdata[8:0];
          REG_IMG_H:   frame_height <= pwdata[8:0];
          default:     ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_CHUNK_W: prdata = APB_DATA_W'(chunk_width);
      REG_CHUNK_H: prdata = APB_DATA_W'(chunk_height);
      REG_IMG_W:   prdata = APB_DATA_W'(frame_width);
      REG_IMG_H:   prdata = APB_DATA_W'(frame_height);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    eff_cw = (chunk_width == '0) ? 5'd1 : ((chunk_width > C_CAP) ? C_CAP : chunk_width);
    eff_ch = (chunk_height == '0) ? 5'd1 : ((chunk_height > C_CAP) ? C_CAP : chunk_height);
    eff_w  = (frame_width == '0) ? 9'd1 : ((frame_width > W_CAP) ? W_CAP : frame_width);
    eff_h  = (frame_height == '0) ? 9'd1 : ((frame_height > H_CAP) ? H_CAP : frame_height);
  end

  tip_div u_div_rows (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (DIV_NUM_W'(eff_h) + DIV_NUM_W'(eff_ch) - DIV_NUM_W'(1)),
    .den  (eff_ch),
    .busy (rows_busy),
    .quot (rows)
  );

  tip_div u_div_cols (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (DIV_NUM_W'(eff_w) + DIV_NUM_W'(eff_cw) - DIV_NUM_W'(1)),
    .den  (eff_cw),
    .busy (cols_busy),
    .quot (cols)
  );

  always_comb begin
    dims.ok   = !stale && !rows_busy && !cols_busy;
    dims.cw   = eff_cw;
    dims.ch   = eff_ch;
    dims.w    = eff_w;
    dims.h    = eff_h;
    dims.rows = rows;
    dims.cols = cols;
  end

endmodule

### rtl/tip_frame_mem.sv
// Frame store: one byte per pixel, one write and one registered read port.
// Depends on nothing.
module tip_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tiled_image_packer_8bit_color_top.sv
// Top level of the tiled 8-bit color image packer: load and emit sequencing.
// Depends on tip_pkg, tip_regs and tip_frame_mem.
//
// Takes one command per cycle whenever busy is low. A load command packs the
// pixel to green 3, red 3, blue 2 bits, registers it and writes it to the
// frame store in the following cycle; it gives no result. An emit command
// gives exactly one byte of the stream (magic, chunk dimension byte, chunk
// row and column counts, chunk pixels, then a period byte flagged last) on
// result through the e1 and e2 registers, the frame store's registered read
// port standing in for e2 on pixel bytes. Results come out in command order
// and cannot be stalled. Busy is high after reset and after every register
// write while the chunk counts are recomputed by a bit-serial divider.
module tiled_image_packer_8bit_color_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_CHUNK  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tip_pkg::cmd_t                  cmd,
  output logic                           result_valid,
  output tip_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tip_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tip_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tip_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tip_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CIW   = $clog2(MAX_WIDTH);
  localparam int RIW   = $clog2(MAX_HEIGHT);
  localparam int SW    = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;
  localparam int LCW   = ((CIW > 9) ? CIW : 9) + 1;
  localparam int LRW   = ((RIW > 9) ? RIW : 9) + 1;

  dims_t dims;
  logic  accept;
  logic  ld_go;
  logic  em_go;

  logic [CIW-1:0] load_col, load_col_next;
  logic [RIW-1:0] load_row, load_row_next;
  logic [CIW-1:0] col_w;
  logic [RIW-1:0] row_w;
  logic [LCW-1:0] col_inc;
  logic [LRW-1:0] row_inc;
  logic           ld_valid;
  logic [AW-1:0]  ld_addr;
  logic [7:0]     ld_data;

  phase_t         emit_phase, emit_phase_next;
  logic [2:0]     header_index, header_index_next;
  logic [7:0]     tile_row, tile_row_next;
  logic [7:0]     tile_col, tile_col_next;
  logic [SW-1:0]  sub_row, sub_row_next;
  logic [SW-1:0]  sub_col, sub_col_next;
  logic [4:0]     sc_inc;
  logic [4:0]     sr_inc;
  logic [8:0]     tc_inc;
  logic [8:0]     tr_inc;
  logic [7:0]     em_byte;
  logic           em_last;
  logic           em_fetch;

  logic             e1_valid;
  logic             e1_fetch;
  logic [7:0]       e1_byte;
  logic             e1_last;
  logic [POS_W-1:0] e1_prow;
  logic [POS_W-1:0] e1_pcol;
  logic             in_rng;
  logic [AW-1:0]    rd_addr;
  logic             e2_valid;
  logic             e2_fetch;
  logic             e2_rng;
  logic [7:0]       e2_byte;
  logic             e2_last;
  logic [7:0]       rdata;

  assign pready = 1'b1;
  assign busy   = !dims.ok;
  assign accept = start && !busy;
  assign ld_go  = accept && (cmd.opcode == OP_LOAD);
  assign em_go  = accept && (cmd.opcode == OP_EMIT);

  tip_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .dims   (dims)
  );

  always_comb begin
    col_w   = (LCW'(load_col) >= LCW'(dims.w)) ? '0 : load_col;
    row_w   = (LRW'(load_row) >= LRW'(dims.h)) ? '0 : load_row;
    col_inc = LCW'(col_w) + LCW'(1);
    row_inc = LRW'(row_w) + LRW'(1);
    load_col_next = CIW'(col_inc);
    load_row_next = row_w;
    if (col_inc >= LCW'(dims.w)) begin
      load_col_next = '0;
      load_row_next = (row_inc >= LRW'(dims.h)) ? '0 : RIW'(row_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_col <= '0;
      load_row <= '0;
      ld_valid <= 1'b0;
    end else begin
      ld_valid <= ld_go;
      if (ld_go) begin
        load_col <= load_col_next;
        load_row <= load_row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_go) begin
      ld_addr <= AW'(row_w) * AW'(MAX_WIDTH) + AW'(col_w);
      ld_data <= pack_pixel(cmd.red, cmd.green, cmd.blue);
    end
  end

  always_comb begin
    emit_phase_next   = emit_phase;
    header_index_next = header_index;
    tile_row_next     = tile_row;
    tile_col_next     = tile_col;
    sub_row_next      = sub_row;
    sub_col_next      = sub_col;
    em_byte           = '0;
    em_last           = 1'b0;
    em_fetch          = 1'b0;
    sc_inc            = 5'(sub_col) + 5'd1;
    sr_inc            = 5'(sub_row) + 5'd1;
    tc_inc            = 9'(tile_col) + 9'd1;
    tr_inc            = 9'(tile_row) + 9'd1;
    case (emit_phase)
      PH_HEADER: begin
        if (header_index inside {[3'd0:3'd3]}) begin
          em_byte = MAGIC_BYTES[header_index[1:0]];
        end else if (header_index == HDR_DIMS) begin
          em_byte = {4'(dims.cw - 5'd1), 4'(dims.ch - 5'd1)};
        end else if (header_index == HDR_ROWS) begin
          em_byte = dims.rows;
        end else begin
          em_byte = dims.cols;
        end
        header_index_next = header_index + 3'd1;
        if (header_index >= HDR_LAST) begin
          header_index_next = '0;
          tile_row_next     = '0;
          tile_col_next     = '0;
          sub_row_next      = '0;
          sub_col_next      = '0;
          emit_phase_next   = (dims.rows != '0 && dims.cols != '0) ? PH_DATA : PH_END;
        end
      end
      PH_DATA: begin
        em_fetch     = 1'b1;
        sub_col_next = SW'(sc_inc);
        if (sc_inc >= dims.cw) begin
          sub_col_next = '0;
          sub_row_next = SW'(sr_inc);
          if (sr_inc >= dims.ch) begin
            sub_row_next  = '0;
            tile_col_next = tc_inc[7:0];
            if (tc_inc >= {1'b0, dims.cols}) begin
              tile_col_next = '0;
              tile_row_next = tr_inc[7:0];
              if (tr_inc >= {1'b0, dims.rows}) begin
                tile_row_next   = '0;
                emit_phase_next = PH_END;
              end
            end
          end
        end
      end
      PH_END: begin
        em_byte           = END_BYTE;
        em_last           = 1'b1;
        emit_phase_next   = PH_HEADER;
        header_index_next = '0;
        tile_row_next     = '0;
        tile_col_next     = '0;
        sub_row_next      = '0;
        sub_col_next      = '0;
      end
      default: begin
        emit_phase_next = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_phase   <= PH_HEADER;
      header_index <= '0;
      tile_row     <= '0;
      tile_col     <= '0;
      sub_row      <= '0;
      sub_col      <= '0;
      e1_valid     <= 1'b0;
      e2_valid     <= 1'b0;
    end else begin
      e1_valid <= em_go;
      e2_valid <= e1_valid;
      if (em_go) begin
        emit_phase   <= emit_phase_next;
        header_index <= header_index_next;
        tile_row     <= tile_row_next;
        tile_col     <= tile_col_next;
        sub_row      <= sub_row_next;
        sub_col      <= sub_col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em_go) begin
      e1_fetch <= em_fetch;
      e1_byte  <= em_byte;
      e1_last  <= em_last;
      e1_prow  <= POS_W'(tile_row) * POS_W'(dims.ch) + POS_W'(sub_row);
      e1_pcol  <= POS_W'(tile_col) * POS_W'(dims.cw) + POS_W'(sub_col);
    end
    if (e1_valid) begin
      e2_fetch <= e1_fetch;
      e2_rng   <= in_rng;
      e2_byte  <= e1_byte;
      e2_last  <= e1_last;
    end
  end

  assign in_rng  = (e1_prow < POS_W'(dims.h)) && (e1_pcol < POS_W'(dims.w));
  assign rd_addr = AW'(e1_prow) * AW'(MAX_WIDTH) + AW'(e1_pcol);

  tip_frame_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (ld_valid),
    .waddr(ld_addr),
    .wdata(ld_data),
    .re   (e1_valid && e1_fetch && in_rng),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign result_valid     = e2_valid;
  assign result.out_byte  = e2_fetch ? (e2_rng ? rdata : 8'h00) : e2_byte;
  assign result.last_byte = e2_last;

endmodule

### rtl/tip_checker.sv
// Port-level checks on the tiled 8-bit color image packer, bound to its top.
// Depends on tip_pkg and tiled_image_packer_8bit_color_top.
module tip_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input tip_pkg::cmd_t    cmd,
  input logic             result_valid,
  input tip_pkg::result_t result,
  input logic             psel,
  input logic             penable,
  input logic             pwrite
);
  import tip_pkg::*;

  a_emit_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.opcode == OP_EMIT) |=> ##1 result_valid)
    else $error("emit transaction without result");

  a_result_has_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && cmd.opcode == OP_EMIT, 2))
    else $error("result without emit transaction");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_byte) |-> (result.out_byte == END_BYTE))
    else $error("last byte is not the end mark");

  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy)
    else $error("ready before chunk counts are known");

  a_busy_after_write: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite) |=> busy)
    else $error("ready right after a register write");

endmodule

bind tiled_image_packer_8bit_color_top tip_checker u_tip_checker (.*);
